@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the scheduler top module
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion lbl failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion lbl failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ design/pps_pkg.sv @@
// ---------------------------------------------------------------------------
// pps_pkg
// Types and constants of the preemptive priority scheduler
// ---------------------------------------------------------------------------
package pps_pkg;

   localparam int CLOCK_W = 20;
   localparam int PRIO_W  = 8;
   localparam int TIME_W  = 16;
   localparam int SLOT_W  = 3;
   localparam int COUNT_W = 4;

   localparam logic [CLOCK_W-1:0] CLOCK_MAX        = '1;
   localparam logic [COUNT_W-1:0] TASK_COUNT_RESET = 4'd5;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // best candidate so far, handed from cell to cell
   typedef struct packed {
      logic              found;
      logic [PRIO_W-1:0] prio;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic              last;    // one unit left before completion
   } tok_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [TIME_W-1:0] burst;
      logic [TIME_W-1:0] arrival;
   } load_type;

   typedef struct packed {
      logic load;
      logic run;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT,
      ST_EMIT
   } state_type;

endpackage

@@ design/preemptive_priority_scheduler.sv @@
// A load passes through the states COMMIT and EMIT before its result is registered;
// a tick first passes through SCAN while the candidate runs once down the chain of
// MAX_TASKS cells. A new request is taken only in IDLE, after EMIT has issued its result.
// Reset (synchronous, active high) clears remaining times, done marks, clock,
// task_count to 5 and rsp_valid; slot priority, burst, arrival and result data do not reset.
// ---------------------------------------------------------------------------
// preemptive_priority_scheduler
// Tick-driven preemptive priority scheduler over a chain of task cells
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module preemptive_priority_scheduler import pps_pkg::*; #(
   parameter int MAX_TASKS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [COUNT_W-1:0]  csr_wdata,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_func,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [PRIO_W-1:0]   req_task_priority,
   input  logic [TIME_W-1:0]   req_burst_length,
   input  logic [TIME_W-1:0]   req_arrival_tick,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_busy_res,
   output logic [SLOT_W-1:0]   rsp_running_slot,
   output logic                rsp_finished,
   output logic [CLOCK_W-1:0]  rsp_turnaround,
   output logic [CLOCK_W-1:0]  rsp_waiting,
   output logic                rsp_all_done,
   output logic [CLOCK_W-1:0]  rsp_now
);

   localparam int IDX_W = $clog2(MAX_TASKS);

   state_type           state_ff;
   state_type           state_in;
   logic [IDX_W-1:0]    scan_cnt_ff;
   logic [COUNT_W-1:0]  task_count_ff;
   logic [CLOCK_W-1:0]  clock_ff;
   logic [CLOCK_W-1:0]  clock_inc;

   logic                func_ff;
   logic [SLOT_W-1:0]   slot_ff;
   load_type            load_ff;
   load_type            load_in;

   logic                res_busy_ff;
   logic [SLOT_W-1:0]   res_slot_ff;
   logic                res_fin_ff;
   logic [CLOCK_W-1:0]  res_t_ff;
   logic [TIME_W-1:0]   res_burst_ff;
   logic [CLOCK_W-1:0]  wait_val;

   logic                rsp_valid_ff;
   logic                busy_out_ff;
   logic [SLOT_W-1:0]   slot_out_ff;
   logic                fin_out_ff;
   logic [CLOCK_W-1:0]  tat_out_ff;
   logic [CLOCK_W-1:0]  wait_out_ff;
   logic                all_done_out_ff;
   logic [CLOCK_W-1:0]  now_out_ff;

   logic                accept;
   logic                scan_last;
   logic                commit_go;
   logic                emit_go;
   logic                out_free;
   logic                slot_ok;
   logic                all_done;
   logic                run_go;

   tok_type             tok_chain [0:MAX_TASKS];
   logic [IDX_W-1:0]    idx_chain [0:MAX_TASKS];
   cell_ctl_type        ctl       [0:MAX_TASKS-1];
   logic [MAX_TASKS-1:0] in_use;
   logic [MAX_TASKS-1:0] done_vec;
   tok_type             win;
   logic [IDX_W-1:0]    win_idx;

   // ---------------- control ----------------

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign scan_last = (scan_cnt_ff == IDX_W'(MAX_TASKS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_func == FUNC_TICK) ? ST_SCAN : ST_COMMIT;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      commit_go = 1'b0;
      emit_go   = 1'b0;
      case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_SCAN:   req_stall = 1'b1;
         ST_COMMIT: commit_go = 1'b1;
         ST_EMIT:   emit_go   = out_free;
         default:   req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_cnt_ff   <= '0;
         task_count_ff <= TASK_COUNT_RESET;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_SCAN) begin
            scan_cnt_ff <= scan_cnt_ff + IDX_W'(1);
         end else begin
            scan_cnt_ff <= '0;
         end
         if (csr_write) begin
            task_count_ff <= csr_wdata;
         end
      end
   end

   // ---------------- item capture ----------------

   always_comb begin
      load_in.prio    = req_task_priority;
      load_in.burst   = (req_burst_length == '0) ? TIME_W'(1) : req_burst_length;
      load_in.arrival = req_arrival_tick;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         slot_ff <= req_slot;
         load_ff <= load_in;
      end
   end

   assign slot_ok = (int'(slot_ff) < MAX_TASKS);

   // ---------------- cell chain ----------------

   assign tok_chain[0] = '0;
   assign idx_chain[0] = '0;
   assign win          = tok_chain[MAX_TASKS];
   assign win_idx      = idx_chain[MAX_TASKS];
   assign all_done     = &(done_vec | ~in_use);
   assign run_go       = commit_go && (func_ff == FUNC_TICK) && !all_done && win.found;

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      // a task count of zero still uses the first slot
      assign in_use[i]   = (i == 0) || (int'(task_count_ff) > i);
      assign ctl[i].load = commit_go && (func_ff == FUNC_LOAD) && (int'(slot_ff) == i);
      assign ctl[i].run  = run_go && (int'(win_idx) == i);

      pps_cell #(
         .INDEX (i),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl[i]),
         .load_data (load_ff),
         .in_use    (in_use[i]),
         .clock_now (clock_ff),
         .tok_in    (tok_chain[i]),
         .idx_in    (idx_chain[i]),
         .tok_out   (tok_chain[i+1]),
         .idx_out   (idx_chain[i+1]),
         .done_out  (done_vec[i])
      );
   end

   // ---------------- commit ----------------

   assign clock_inc = (clock_ff == CLOCK_MAX) ? clock_ff : clock_ff + CLOCK_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff <= '0;
      end else if (commit_go) begin
         if (func_ff == FUNC_LOAD) begin
            if (slot_ok) begin
               clock_ff <= '0;
            end
         end else if (!all_done) begin
            clock_ff <= clock_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit_go) begin
         res_busy_ff  <= run_go;
         res_fin_ff   <= run_go && win.last;
         res_slot_ff  <= SLOT_W'(win_idx);
         res_t_ff     <= clock_inc - {{(CLOCK_W-TIME_W){1'b0}}, win.arrival};
         res_burst_ff <= win.burst;
      end
   end

   // ---------------- result register ----------------

   // waiting floors at zero after a reload mid-run
   assign wait_val = (res_t_ff > {{(CLOCK_W-TIME_W){1'b0}}, res_burst_ff}) ?
                     res_t_ff - {{(CLOCK_W-TIME_W){1'b0}}, res_burst_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         busy_out_ff     <= res_busy_ff;
         slot_out_ff     <= res_busy_ff ? res_slot_ff : '0;
         fin_out_ff      <= res_fin_ff;
         tat_out_ff      <= res_fin_ff ? res_t_ff : '0;
         wait_out_ff     <= res_fin_ff ? wait_val : '0;
         all_done_out_ff <= all_done;
         now_out_ff      <= clock_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_busy_res     = busy_out_ff;
   assign rsp_running_slot = slot_out_ff;
   assign rsp_finished     = fin_out_ff;
   assign rsp_turnaround   = tat_out_ff;
   assign rsp_waiting      = wait_out_ff;
   assign rsp_all_done     = all_done_out_ff;
   assign rsp_now          = now_out_ff;

   // ---------------- assertions ----------------

   `ASSERT_NEXT(a_accept_stalls, clock, reset, accept, req_stall)
   `ASSERT_IMPLY(a_fin_busy, clock, reset, rsp_valid && rsp_finished, rsp_busy_res)
   `ASSERT_IMPLY(a_idle_slot, clock, reset, rsp_valid && !rsp_busy_res, (rsp_running_slot == '0) && (rsp_turnaround == '0))
   `ASSERT_IMPLY(a_wait_le_tat, clock, reset, rsp_valid, rsp_waiting <= rsp_turnaround)

endmodule

@@ design/pps_cell.sv @@
// ---------------------------------------------------------------------------
// pps_cell
// One task slot: holds the slot state and forwards the better candidate
// ---------------------------------------------------------------------------
module pps_cell import pps_pkg::*; #(
   parameter int INDEX = 0,
   parameter int IDX_W = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  cell_ctl_type        ctl,
   input  load_type            load_data,
   input  logic                in_use,
   input  logic [CLOCK_W-1:0]  clock_now,
   input  tok_type             tok_in,
   input  logic [IDX_W-1:0]    idx_in,
   output tok_type             tok_out,
   output logic [IDX_W-1:0]    idx_out,
   output logic                done_out
);

   logic [PRIO_W-1:0] prio_ff;
   logic [TIME_W-1:0] burst_ff;
   logic [TIME_W-1:0] arrival_ff;
   logic [TIME_W-1:0] remaining_ff;
   logic              done_ff;
   tok_type           tok_ff;
   tok_type           tok_in_c;
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  idx_in_c;
   logic              eligible;
   logic              better;

   always_comb begin
      eligible = in_use && !done_ff && (remaining_ff != '0) &&
                 ({{(CLOCK_W-TIME_W){1'b0}}, arrival_ff} <= clock_now);
      better = eligible && (!tok_in.found || (prio_ff > tok_in.prio) ||
               ((prio_ff == tok_in.prio) && (arrival_ff < tok_in.arrival)));
      if (better) begin
         tok_in_c.found   = 1'b1;
         tok_in_c.prio    = prio_ff;
         tok_in_c.arrival = arrival_ff;
         tok_in_c.burst   = burst_ff;
         tok_in_c.last    = (remaining_ff == TIME_W'(1));
         idx_in_c         = IDX_W'(INDEX);
      end else begin
         tok_in_c = tok_in;
         idx_in_c = idx_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in_c;
      idx_ff <= idx_in_c;
      if (ctl.load) begin
         prio_ff    <= load_data.prio;
         burst_ff   <= load_data.burst;
         arrival_ff <= load_data.arrival;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         done_ff      <= 1'b0;
      end else if (ctl.load) begin
         remaining_ff <= load_data.burst;
         done_ff      <= 1'b0;
      end else if (ctl.run) begin
         remaining_ff <= remaining_ff - TIME_W'(1);
         if (remaining_ff == TIME_W'(1)) begin
            done_ff <= 1'b1;
         end
      end
   end

   assign tok_out  = tok_ff;
   assign idx_out  = idx_ff;
   assign done_out = done_ff;

endmodule
